// File: rtl/bfas_pkg.sv
// Shared types and codes for the byte FIFO with auto send.
// No dependencies; every other file in rtl/ refers to this package.
`default_nettype none

package bfas_pkg;

	localparam int OPCODE_W   = 2;
	localparam int BYTE_W     = 8;
	localparam int STATUS_W   = 2;
	localparam int FILL_W     = 6;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 8;
	localparam int SIZE_W     = 3;

	localparam logic [OPCODE_W-1:0] OP_PUT   = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_GET   = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_POP   = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_FLUSH = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_AUTO_SEND = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LOG2 = 4'd1;

	localparam logic [SIZE_W-1:0] SIZE_LOG2_RESET = 3'd6;

	// controller to datapath
	typedef struct packed {
		logic accept;   // latch the input beat
		logic exec;     // run one step of the latched operation and load the result
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic slot_free;   // result register can take a result this cycle
		logic flush_more;  // the step now running leaves bytes for further flush steps
	} sts_t;

endpackage

`default_nettype wire

// File: rtl/bfas_if.sv
// Channel interfaces: operation input, result output, register write port.
// Depends on bfas_pkg for field widths.
`default_nettype none

interface bfas_in_if;
	logic                               valid;
	logic                               ready;
	logic [bfas_pkg::OPCODE_W-1:0]      opcode;
	logic [bfas_pkg::BYTE_W-1:0]        data_byte;

	modport source (output valid, output opcode, output data_byte, input ready);
	modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

interface bfas_out_if;
	logic                               valid;
	logic                               ready;
	logic [bfas_pkg::STATUS_W-1:0]      status;
	logic                               byte_valid;
	logic [bfas_pkg::BYTE_W-1:0]        out_byte;
	logic                               last;
	logic [bfas_pkg::FILL_W-1:0]        fill_level;
	logic                               idle_flag;

	modport source (output valid, output status, output byte_valid, output out_byte,
		output last, output fill_level, output idle_flag, input ready);
	modport sink   (input valid, input status, input byte_valid, input out_byte,
		input last, input fill_level, input idle_flag, output ready);
endinterface

interface bfas_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [bfas_pkg::CFG_IDX_W-1:0]     index;
	logic [bfas_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/bfas_ctrl.sv
// Controller FSM: accepts an operation, then issues execute steps until the
// operation (a flush may take many) is done. Depends on bfas_pkg.
`default_nettype none

module bfas_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	output bfas_pkg::cmd_t cmd,
	input  bfas_pkg::sts_t sts
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic state_n;

	// register writes win over a new beat in the same cycle
	assign cfg_ready = (state_q == ST_IDLE);
	assign in_ready  = (state_q == ST_IDLE) && !cfg_valid;

	assign cmd.accept = in_valid && in_ready;
	assign cmd.exec   = (state_q == ST_EXEC) && sts.slot_free;

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.accept) state_n = ST_EXEC;
			end
			ST_EXEC: begin
				if (cmd.exec && !sts.flush_more) state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

endmodule

`default_nettype wire

// File: rtl/bfas_dp.sv
// Datapath: byte ring memory, write/read indices, idle flag, config registers
// and the result register. Depends on bfas_pkg.
`default_nettype none

module bfas_dp #(
	parameter int DEPTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bfas_pkg::cmd_t                    cmd,
	output bfas_pkg::sts_t                    sts,
	input  logic [bfas_pkg::OPCODE_W-1:0]     opcode,
	input  logic [bfas_pkg::BYTE_W-1:0]       data_byte,
	input  logic                              cfg_we,
	input  logic [bfas_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bfas_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [bfas_pkg::STATUS_W-1:0]     out_status,
	output logic                              out_byte_valid,
	output logic [bfas_pkg::BYTE_W-1:0]       out_byte,
	output logic                              out_last,
	output logic [bfas_pkg::FILL_W-1:0]       out_fill_level,
	output logic                              out_idle_flag
);

	localparam int IW = $clog2(DEPTH);

	// clamp log2 size to 1..6, cap the size at DEPTH, give size minus one
	function automatic logic [IW-1:0] ring_mask(input logic [bfas_pkg::SIZE_W-1:0] lg);
		logic [bfas_pkg::SIZE_W-1:0] l;
		logic [6:0]                  sz;
		l = lg;
		if (l < 3'd1) l = 3'd1;
		if (l > 3'd6) l = 3'd6;
		sz = 7'd1 << l;
		if (sz > 7'(DEPTH)) sz = 7'(DEPTH);
		return IW'(sz - 7'd1);
	endfunction

	logic [bfas_pkg::BYTE_W-1:0]   mem_q [DEPTH];
	logic [bfas_pkg::BYTE_W-1:0]   rdata_q;

	logic [bfas_pkg::OPCODE_W-1:0] op_q;
	logic [bfas_pkg::BYTE_W-1:0]   data_q;
	logic [IW-1:0]                 w_q, r_q, mask_q;
	logic                          idle_q, auto_q;
	logic                          out_valid_q;

	logic [IW-1:0]                 w_n, r_n, w_inc, r_inc, cfg_mask, fill;
	logic                          idle_n, empty, full, mem_we, flush_more, size_we;
	logic [bfas_pkg::STATUS_W-1:0] res_status;
	logic                          res_bv, res_last;
	logic [bfas_pkg::BYTE_W-1:0]   res_byte;

	assign cfg_mask = ring_mask(cfg_data[bfas_pkg::SIZE_W-1:0]);
	assign size_we  = cfg_we && (cfg_index == bfas_pkg::CFG_SIZE_LOG2);

	assign empty = (w_q == r_q);
	assign full  = (w_q == ((r_q - IW'(1)) & mask_q));
	assign w_inc = (w_q + IW'(1)) & mask_q;
	assign r_inc = (r_q + IW'(1)) & mask_q;

	always_comb begin
		w_n        = w_q;
		r_n        = r_q;
		idle_n     = idle_q;
		mem_we     = 1'b0;
		res_status = bfas_pkg::ST_OK;
		res_bv     = 1'b0;
		res_byte   = '0;
		res_last   = 1'b1;
		flush_more = 1'b0;
		if (cmd.exec) begin
			case (op_q)
				bfas_pkg::OP_PUT: begin
					if (full) begin
						res_status = bfas_pkg::ST_FULL;
					end else begin
						mem_we = 1'b1;
						w_n    = w_inc;
						if (idle_q && auto_q) begin
							// on an empty ring the byte sent is the one just stored
							res_bv   = 1'b1;
							res_byte = empty ? data_q : rdata_q;
							r_n      = r_inc;
							idle_n   = 1'b0;
						end
					end
				end
				bfas_pkg::OP_GET, bfas_pkg::OP_POP: begin
					if (empty) begin
						res_status = bfas_pkg::ST_EMPTY;
						idle_n     = 1'b1;
					end else begin
						res_bv   = 1'b1;
						res_byte = rdata_q;
						r_n      = r_inc;
						idle_n   = 1'b0;
					end
				end
				bfas_pkg::OP_FLUSH: begin
					if (empty) begin
						idle_n = 1'b1;
					end else begin
						res_bv   = 1'b1;
						res_byte = rdata_q;
						r_n      = r_inc;
						if (r_inc == w_q) begin
							idle_n = 1'b1;
						end else begin
							idle_n     = 1'b0;
							res_last   = 1'b0;
							flush_more = 1'b1;
						end
					end
				end
				default: ;
			endcase
		end else if (size_we) begin
			w_n = w_q & cfg_mask;
			r_n = r_q & cfg_mask;
		end
	end

	assign fill = (w_n - r_n) & mask_q;

	assign sts.slot_free  = !out_valid_q || out_ready;
	assign sts.flush_more = flush_more;

	// read the next read position so the oldest byte is always registered
	always_ff @(posedge clk) begin
		if (mem_we) mem_q[w_q] <= data_q;
		rdata_q <= mem_q[r_n];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= opcode;
			data_q <= data_byte;
		end
		if (cmd.exec) begin
			out_status     <= res_status;
			out_byte_valid <= res_bv;
			out_byte       <= res_byte;
			out_last       <= res_last;
			out_fill_level <= bfas_pkg::FILL_W'(fill);
			out_idle_flag  <= idle_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q         <= '0;
			r_q         <= '0;
			idle_q      <= 1'b1;
			auto_q      <= 1'b0;
			mask_q      <= ring_mask(bfas_pkg::SIZE_LOG2_RESET);
			out_valid_q <= 1'b0;
		end else begin
			w_q    <= w_n;
			r_q    <= r_n;
			idle_q <= idle_n;
			if (cfg_we && (cfg_index == bfas_pkg::CFG_AUTO_SEND)) auto_q <= cfg_data[0];
			if (size_we) mask_q <= cfg_mask;
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// File: rtl/byte_fifo_auto_send.sv
// Top level of the byte FIFO with auto send: controller plus datapath.
// Depends on bfas_pkg, bfas_if, bfas_ctrl and bfas_dp.
//
//  channel | role   | payload                                          | beat when
//  in_ch   | sink   | opcode, data_byte                                | valid && ready
//  out_ch  | source | status, byte_valid, out_byte, last, fill_level,  | valid && ready
//          |        | idle_flag                                        |
//  cfg     | sink   | index (0 auto_send, 1 size_log2), data           | valid && ready
//
// Put, get and pop are accepted in the idle state, then executed in a single step.
// A flush executes one step per stored byte, each step one ring read;
// a flush of an empty ring executes in a single step, like the other operations.
// The registered read port of the ring memory has the next byte ready for each step.
// Reset clears indices and registers, sets the idle flag; the ring needs no clearing.
// A result waits in the output register; execution holds while it is not taken.
// A register write has priority over an input beat offered in the same cycle.
`default_nettype none

module byte_fifo_auto_send #(
	parameter int DEPTH = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	bfas_in_if.sink   in_ch,
	bfas_out_if.source out_ch,
	bfas_cfg_if.sink  cfg
);

	bfas_pkg::cmd_t cmd;
	bfas_pkg::sts_t sts;

	bfas_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.cfg_valid (cfg.valid),
		.cfg_ready (cfg.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	bfas_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.opcode         (in_ch.opcode),
		.data_byte      (in_ch.data_byte),
		.cfg_we         (cfg.valid && cfg.ready),
		.cfg_index      (cfg.index),
		.cfg_data       (cfg.data),
		.out_valid      (out_ch.valid),
		.out_ready      (out_ch.ready),
		.out_status     (out_ch.status),
		.out_byte_valid (out_ch.byte_valid),
		.out_byte       (out_ch.out_byte),
		.out_last       (out_ch.last),
		.out_fill_level (out_ch.fill_level),
		.out_idle_flag  (out_ch.idle_flag)
	);

endmodule

`default_nettype wire

// File: rtl/bfas_chk.sv
// Port-level checker for byte_fifo_auto_send, attached by bind below.
// Depends on bfas_pkg and the top level's channel interfaces.
`default_nettype none

module bfas_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [bfas_pkg::STATUS_W-1:0] status,
	input logic                          byte_valid,
	input logic                          last,
	input logic [bfas_pkg::FILL_W-1:0]   fill_level,
	input logic                          idle_flag
);

	// a stalled result beat stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	// full or empty reports carry no byte
	a_err_nobyte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == bfas_pkg::ST_FULL || status == bfas_pkg::ST_EMPTY)
		|-> !byte_valid)
		else $error("error status with a byte");

	// only a flush leaves results unmarked, each with a byte and the sender busy
	a_mid_flush: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> byte_valid && !idle_flag && status == bfas_pkg::ST_OK)
		else $error("bad non-final result");

	// a byte sent with the sender going idle can only be the end of a flush
	a_flush_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_valid && idle_flag |-> fill_level == '0)
		else $error("sender idle while bytes remain");

	// an empty report marks the sender idle
	a_empty_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == bfas_pkg::ST_EMPTY |-> idle_flag && fill_level == '0)
		else $error("empty report with sender busy or bytes stored");

endmodule

bind byte_fifo_auto_send bfas_chk u_bfas_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.status     (out_ch.status),
	.byte_valid (out_ch.byte_valid),
	.last       (out_ch.last),
	.fill_level (out_ch.fill_level),
	.idle_flag  (out_ch.idle_flag)
);

`default_nettype wire

// File: bench/tb_top.sv
// Testbench for byte_fifo_auto_send: directed and random operation traffic,
// checked beat by beat against a predictor of the ring inside this file.
// Depends on rtl/bfas_pkg.sv, rtl/bfas_if.sv and the byte_fifo_auto_send RTL.
`default_nettype none

module tb_top;

	localparam int LIMIT_CYCLES = 400000;
	localparam int TAIL_CYCLES  = 20;
	localparam int MAX_REPORTS  = 10;
	localparam int FLUSH_CAP    = 63;
	localparam logic [bfas_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 4'd2;
	localparam logic [bfas_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 4'hF;

	typedef struct packed {
		logic [bfas_pkg::STATUS_W-1:0] status;
		logic                          byte_valid;
		logic [bfas_pkg::BYTE_W-1:0]   out_byte;
		logic                          last;
		logic [bfas_pkg::FILL_W-1:0]   fill_level;
		logic                          idle_flag;
	} fifo_result_t;

	logic clk;
	logic arst_n;

	bfas_in_if  in_ch();
	bfas_out_if out_ch();
	bfas_cfg_if cfg();

	byte_fifo_auto_send DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg)
	);

	// ring predictor state
	logic [bfas_pkg::BYTE_W-1:0] ring_model [64];
	logic [bfas_pkg::FILL_W-1:0] wr_ptr;
	logic [bfas_pkg::FILL_W-1:0] rd_ptr;
	logic                        send_idle;
	logic                        auto_on;
	logic [bfas_pkg::SIZE_W-1:0] size_sel;
	fifo_result_t                pending_results [$];

	int err_count    = 0;
	int ops_sent     = 0;
	int beats_seen   = 0;
	int cfg_writes   = 0;
	int full_hits    = 0;
	int empty_hits   = 0;
	int deepest_flush = 0;
	int burst_left   = 0;
	bit gaps_on      = 1'b1;
	int cycle_cnt    = 0;

	logic [7:0] stall_tick = '0;
	logic [1:0] stall_mode = '0;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic logic [bfas_pkg::FILL_W-1:0] size_mask(
		input logic [bfas_pkg::SIZE_W-1:0] lg);
		logic [bfas_pkg::SIZE_W-1:0] e;
		e = lg;
		if (e < 3'd1) e = 3'd1;
		if (e > 3'd6) e = 3'd6;
		return 6'h3F >> (6 - e);
	endfunction

	function automatic void push_result(input logic [bfas_pkg::STATUS_W-1:0] st,
		input logic bv, input logic [bfas_pkg::BYTE_W-1:0] b, input logic lst);
		fifo_result_t r;
		r.status     = st;
		r.byte_valid = bv;
		r.out_byte   = b;
		r.last       = lst;
		r.fill_level = (wr_ptr - rd_ptr) & size_mask(size_sel);
		r.idle_flag  = send_idle;
		pending_results.push_back(r);
	endfunction

	function automatic bit take_oldest(output logic [bfas_pkg::BYTE_W-1:0] b);
		b = '0;
		if (wr_ptr == rd_ptr) begin
			send_idle = 1'b1;
			return 1'b0;
		end
		send_idle = 1'b0;
		b = ring_model[rd_ptr];
		rd_ptr = (rd_ptr + 6'd1) & size_mask(size_sel);
		return 1'b1;
	endfunction

	function automatic void predict_fifo_op(input logic [bfas_pkg::OPCODE_W-1:0] op,
		input logic [bfas_pkg::BYTE_W-1:0] data);
		logic [bfas_pkg::FILL_W-1:0] m;
		logic [bfas_pkg::BYTE_W-1:0] b;
		int k;
		bit got;
		bit fin_beat;
		m = size_mask(size_sel);
		b = '0;
		case (op)
		bfas_pkg::OP_PUT: begin
			if (wr_ptr == ((rd_ptr - 6'd1) & m)) begin
				full_hits++;
				push_result(bfas_pkg::ST_FULL, 1'b0, '0, 1'b1);
			end else begin
				ring_model[wr_ptr] = data;
				wr_ptr = (wr_ptr + 6'd1) & m;
				got = 1'b0;
				if (send_idle && auto_on)
					got = take_oldest(b);
				if (got)
					push_result(bfas_pkg::ST_OK, 1'b1, b, 1'b1);
				else
					push_result(bfas_pkg::ST_OK, 1'b0, '0, 1'b1);
			end
		end
		bfas_pkg::OP_GET, bfas_pkg::OP_POP: begin
			if (take_oldest(b)) begin
				push_result(bfas_pkg::ST_OK, 1'b1, b, 1'b1);
			end else begin
				empty_hits++;
				push_result(bfas_pkg::ST_EMPTY, 1'b0, '0, 1'b1);
			end
		end
		default: begin
			if (wr_ptr == rd_ptr) begin
				send_idle = 1'b1;
				push_result(bfas_pkg::ST_OK, 1'b0, '0, 1'b1);
			end else begin
				k = 0;
				while (k < FLUSH_CAP) begin
					if (!take_oldest(b))
						break;
					fin_beat = (wr_ptr == rd_ptr) || (k == FLUSH_CAP - 1);
					if (fin_beat)
						send_idle = 1'b1;
					push_result(bfas_pkg::ST_OK, 1'b1, b, fin_beat);
					k++;
					if (fin_beat)
						break;
				end
				if (k > deepest_flush)
					deepest_flush = k;
			end
		end
		endcase
	endfunction

	function automatic void apply_reg(input logic [bfas_pkg::CFG_IDX_W-1:0] idx,
		input logic [bfas_pkg::CFG_DATA_W-1:0] val);
		if (idx == bfas_pkg::CFG_AUTO_SEND) begin
			auto_on = val[0];
		end else if (idx == bfas_pkg::CFG_SIZE_LOG2) begin
			size_sel = val[bfas_pkg::SIZE_W-1:0];
			wr_ptr = wr_ptr & size_mask(size_sel);
			rd_ptr = rd_ptr & size_mask(size_sel);
		end
	endfunction

	function automatic void note_error(input string msg);
		err_count++;
		if (err_count <= MAX_REPORTS)
			$display("ERROR @%0t: %s", $realtime, msg);
	endfunction

	function automatic string fmt_result(input fifo_result_t r);
		return $sformatf("st=%0d bv=%0d byte=%02h last=%0d fill=%0d idle=%0d",
			r.status, r.byte_valid, r.out_byte, r.last, r.fill_level, r.idle_flag);
	endfunction

	// result checker
	always @(posedge clk) begin
		fifo_result_t got_r;
		fifo_result_t want_r;
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			beats_seen++;
			got_r.status     = out_ch.status;
			got_r.byte_valid = out_ch.byte_valid;
			got_r.out_byte   = out_ch.out_byte;
			got_r.last       = out_ch.last;
			got_r.fill_level = out_ch.fill_level;
			got_r.idle_flag  = out_ch.idle_flag;
			if (pending_results.size() == 0) begin
				note_error({"result beat with nothing pending: ", fmt_result(got_r)});
			end else begin
				want_r = pending_results.pop_front();
				if (got_r !== want_r)
					note_error({"expected ", fmt_result(want_r), " got ",
						fmt_result(got_r)});
			end
		end
	end

	// receiver stall pattern, reshuffled each time the low six bits of stall_tick are zero
	always @(posedge clk) begin
		stall_tick <= stall_tick + 8'd1;
		if (stall_tick[5:0] == 6'd0)
			stall_mode <= 2'($urandom_range(0, 3));
		case (stall_mode)
		2'd0: out_ch.ready <= 1'b1;
		2'd1: out_ch.ready <= 1'($urandom_range(0, 1));
		2'd2: out_ch.ready <= ($urandom_range(0, 3) == 0);
		default: out_ch.ready <= stall_tick[2];
		endcase
	end

	initial begin
		while (cycle_cnt < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("Verification failed");
		$finish;
	end

	task automatic send_op(input logic [bfas_pkg::OPCODE_W-1:0] op,
		input logic [bfas_pkg::BYTE_W-1:0] data);
		in_ch.valid     <= 1'b1;
		in_ch.opcode    <= op;
		in_ch.data_byte <= data;
		@(posedge clk);
		while (in_ch.ready !== 1'b1)
			@(posedge clk);
		predict_fifo_op(op, data);
		ops_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 12);
			if (gaps_on) begin
				in_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	endtask

	// hold the sender until every pending result beat is in
	task automatic quiesce();
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [bfas_pkg::CFG_IDX_W-1:0] idx,
		input logic [bfas_pkg::CFG_DATA_W-1:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		@(posedge clk);
		while (cfg.ready !== 1'b1)
			@(posedge clk);
		cfg.valid <= 1'b0;
		apply_reg(idx, val);
		cfg_writes++;
		@(posedge clk);
	endtask

	// empty the ring so a size change cannot expose unwritten entries
	task automatic drain_ring();
		if (wr_ptr != rd_ptr)
			send_op(bfas_pkg::OP_FLUSH, 8'($urandom_range(0, 255)));
		quiesce();
	endtask

	task automatic set_mode(input logic auto_bit, input logic [bfas_pkg::SIZE_W-1:0] lg);
		logic [bfas_pkg::CFG_DATA_W-1:0] val;
		drain_ring();
		val = 8'($urandom_range(0, 255));
		val[0] = auto_bit;
		write_reg(bfas_pkg::CFG_AUTO_SEND, val);
		val = 8'($urandom_range(0, 255));
		val[bfas_pkg::SIZE_W-1:0] = lg;
		write_reg(bfas_pkg::CFG_SIZE_LOG2, val);
	endtask

	task automatic test_empty_ops();
		send_op(bfas_pkg::OP_GET, 8'h00);
		send_op(bfas_pkg::OP_POP, 8'hFF);
		send_op(bfas_pkg::OP_FLUSH, 8'h00);
	endtask

	task automatic test_put_get_flush();
		send_op(bfas_pkg::OP_PUT, 8'h00);
		send_op(bfas_pkg::OP_PUT, 8'hFF);
		send_op(bfas_pkg::OP_PUT, 8'hA5);
		send_op(bfas_pkg::OP_PUT, 8'h5A);
		send_op(bfas_pkg::OP_GET, 8'h00);
		send_op(bfas_pkg::OP_POP, 8'h00);
		send_op(bfas_pkg::OP_FLUSH, 8'hFF);
	endtask

	task automatic test_auto_send();
		quiesce();
		write_reg(bfas_pkg::CFG_AUTO_SEND, 8'hFF);
		send_op(bfas_pkg::OP_PUT, 8'h3C);
		send_op(bfas_pkg::OP_PUT, 8'hC3);
		send_op(bfas_pkg::OP_GET, 8'h00);
		send_op(bfas_pkg::OP_GET, 8'h00);
		send_op(bfas_pkg::OP_PUT, 8'h81);
		send_op(bfas_pkg::OP_FLUSH, 8'h00);
		quiesce();
		write_reg(bfas_pkg::CFG_AUTO_SEND, 8'h00);
	endtask

	task automatic test_small_ring_full();
		drain_ring();
		// size code 0 acts as the two-entry ring
		write_reg(bfas_pkg::CFG_SIZE_LOG2, 8'hF8);
		send_op(bfas_pkg::OP_PUT, 8'h11);
		send_op(bfas_pkg::OP_PUT, 8'h22);
		send_op(bfas_pkg::OP_FLUSH, 8'h00);
		quiesce();
		write_reg(bfas_pkg::CFG_SIZE_LOG2, 8'h02);
		send_op(bfas_pkg::OP_PUT, 8'h01);
		send_op(bfas_pkg::OP_PUT, 8'h80);
		send_op(bfas_pkg::OP_PUT, 8'h7F);
		send_op(bfas_pkg::OP_PUT, 8'hFE);
		send_op(bfas_pkg::OP_FLUSH, 8'h00);
		quiesce();
		// spare indexes must leave the mode alone
		write_reg(CFG_SPARE_LO, 8'hFF);
		write_reg(CFG_SPARE_HI, 8'h00);
		send_op(bfas_pkg::OP_PUT, 8'h42);
		send_op(bfas_pkg::OP_PUT, 8'h24);
		send_op(bfas_pkg::OP_PUT, 8'h99);
		send_op(bfas_pkg::OP_PUT, 8'h66);
	endtask

	task automatic test_deep_ring();
		int i;
		drain_ring();
		// size code 7 acts as the largest ring
		write_reg(bfas_pkg::CFG_SIZE_LOG2, 8'h07);
		for (i = 0; i < 64; i++)
			send_op(bfas_pkg::OP_PUT, 8'($urandom_range(0, 255)));
		send_op(bfas_pkg::OP_FLUSH, 8'h00);
		quiesce();
		write_reg(bfas_pkg::CFG_SIZE_LOG2, 8'h06);
	endtask

	task automatic test_random_traffic();
		int phase;
		int i;
		int r;
		int put_bias;
		logic [bfas_pkg::OPCODE_W-1:0] op;
		logic [bfas_pkg::SIZE_W-1:0] lg;
		for (phase = 0; phase < 6; phase++) begin
			lg = (phase == 3) ? 3'd6 : 3'($urandom_range(0, 4));
			set_mode(phase[0], lg);
			gaps_on = (phase != 2);
			put_bias = $urandom_range(40, 75);
			for (i = 0; i < 3; i++) begin
				r = $urandom_range(0, 99);
				if (r < put_bias)
					op = bfas_pkg::OP_PUT;
				else if (r < put_bias + (100 - put_bias) * 2 / 5)
					op = bfas_pkg::OP_GET;
				else if (r < put_bias + (100 - put_bias) * 4 / 5)
					op = bfas_pkg::OP_POP;
				else
					op = bfas_pkg::OP_FLUSH;
				send_op(op, 8'($urandom_range(0, 255)));
				if (phase == 4 && i == 1)
					quiesce();
			end
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		arst_n          = 1'b0;
		in_ch.valid     = 1'b0;
		in_ch.opcode    = bfas_pkg::OP_PUT;
		in_ch.data_byte = '0;
		cfg.valid       = 1'b0;
		cfg.index       = bfas_pkg::CFG_AUTO_SEND;
		cfg.data        = '0;
		wr_ptr          = '0;
		rd_ptr          = '0;
		send_idle       = 1'b1;
		auto_on         = 1'b0;
		size_sel        = bfas_pkg::SIZE_LOG2_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_ops();
		test_put_get_flush();
		test_auto_send();
		test_small_ring_full();
		test_deep_ring();
		test_random_traffic();

		quiesce();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			note_error($sformatf("%0d result beats never arrived", pending_results.size()));

		$display("Sent %0d operations with %0d register writes; %0d puts hit full, %0d %s",
			ops_sent, cfg_writes, full_hits, empty_hits, "gets/pops hit empty.");
		$display("Checked %0d result beats, longest flush %0d bytes, %0d errors.",
			beats_seen, deepest_flush, err_count);
		if (err_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

// File: byte_fifo_auto_send.f
rtl/bfas_pkg.sv
rtl/bfas_if.sv
rtl/bfas_ctrl.sv
rtl/bfas_dp.sv
rtl/byte_fifo_auto_send.sv
rtl/bfas_chk.sv
bench/tb_top.sv
